// ----- rtl/swlr_pkg.sv -----
// Package for the stopwatch lap recorder: event codes, lap entry type and defaults.
// Used by swlr_lap_mem and stopwatch_lap_recorder_core; depends on nothing.
package swlr_pkg;

  // Default number of lap history entries.
  localparam int unsigned LapDepthDef = 16;

  // Field widths fixed by the interface.
  localparam int unsigned FuncW     = 3;
  localparam int unsigned IdxW      = 8;
  localparam int unsigned SeqW      = 8;
  localparam int unsigned TickW     = 32;
  localparam int unsigned DebounceW = 16;
  localparam int unsigned LapsW     = 5;

  // Debounce distance after reset.
  localparam logic [DebounceW-1:0] DebounceRst = 16'd52;

  // Event codes carried by each input transaction.
  typedef enum logic [FuncW-1:0] {
    FUNC_TICK   = 3'd0,
    FUNC_EDGE   = 3'd1,
    FUNC_TOGGLE = 3'd2,
    FUNC_RESET  = 3'd3,
    FUNC_LAP    = 3'd4,
    FUNC_READ   = 3'd5
  } func_e;

  // One lap history entry as held in the memory.
  typedef struct packed {
    logic [SeqW-1:0]  seq;
    logic [TickW-1:0] interval;
    logic [TickW-1:0] mark;
  } lap_entry_t;

endpackage

// ----- rtl/swlr_lap_mem.sv -----
// Lap history memory: one write port, one read port with registered read data.
// Depends on swlr_pkg for the lap entry type.
module swlr_lap_mem #(
  parameter int unsigned Depth = swlr_pkg::LapDepthDef,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic                   clk_i,
  input  logic                   we_i,
  input  logic [AddrW-1:0]       waddr_i,
  input  swlr_pkg::lap_entry_t   wdata_i,
  input  logic                   re_i,
  input  logic [AddrW-1:0]       raddr_i,
  output swlr_pkg::lap_entry_t   rdata_o
);
  import swlr_pkg::*;

  lap_entry_t mem_q [Depth];
  lap_entry_t rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port with registered read data; data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/stopwatch_lap_recorder_core.sv -----
// Top level of the stopwatch lap recorder: event decode, counters and result register.
// Depends on swlr_pkg and swlr_lap_mem.

// The core takes one event transaction per clock cycle, stalled only by a held result
// register, and returns exactly one result transaction for each in the cycle after
// acceptance, showing the stopwatch state after that event. Lap history lives in a
// circular buffer memory of LAP_DEPTH entries with a fill count, so a reset event clears
// the history without sweeping the memory. A lap read is issued to the memory in the
// accept cycle and its registered data is presented with the result; a read beyond the
// stored laps returns zeros. The user must write the debounce register through
// cfg_we_i/cfg_wdata_i only while the core is idle; the block does not enforce this.
module stopwatch_lap_recorder_core #(
  parameter int unsigned LAP_DEPTH = swlr_pkg::LapDepthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [swlr_pkg::DebounceW-1:0] cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [swlr_pkg::FuncW-1:0]    func_i,
  input  logic [swlr_pkg::IdxW-1:0]     lap_index_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          running_o,
  output logic [swlr_pkg::TickW-1:0]    elapsed_ticks_o,
  output logic [swlr_pkg::LapsW-1:0]    laps_stored_o,
  output logic                          lap_taken_o,
  output logic                          edge_accepted_o,
  output logic [swlr_pkg::SeqW-1:0]     lap_number_o,
  output logic [swlr_pkg::TickW-1:0]    lap_interval_o,
  output logic [swlr_pkg::TickW-1:0]    lap_elapsed_o,
  output logic [swlr_pkg::TickW-1:0]    free_ticks_o,
  output logic [swlr_pkg::TickW-1:0]    press_count_o,
  output logic [swlr_pkg::TickW-1:0]    bounce_count_o,
  output logic [swlr_pkg::TickW-1:0]    toggle_count_o
);
  import swlr_pkg::*;

  localparam int unsigned AddrW  = $clog2(LAP_DEPTH);
  localparam int unsigned CountW = $clog2(LAP_DEPTH + 1);

  // Configuration.
  logic [DebounceW-1:0] debounce_q;

  // Stopwatch state.
  logic              run_q, run_d;
  logic [TickW-1:0]  elapsed_q, elapsed_d;
  logic [TickW-1:0]  free_q, free_d;
  logic [TickW-1:0]  mark_q, mark_d;
  logic [CountW-1:0] count_q, count_d;
  logic [SeqW-1:0]   seq_q, seq_d;
  logic [AddrW-1:0]  wptr_q, wptr_d;
  logic [TickW-1:0]  last_edge_q, last_edge_d;
  logic              edge_seen_q, edge_seen_d;
  logic [TickW-1:0]  presses_q, presses_d;
  logic [TickW-1:0]  bounces_q, bounces_d;
  logic [TickW-1:0]  toggles_q, toggles_d;

  // Result register flags.
  logic out_valid_q, out_valid_d;
  logic taken_q, taken_d;
  logic accepted_q, accepted_d;
  logic hit_q, hit_d;

  // Memory access.
  logic             in_acc;
  logic             edge_ok;
  logic             mem_we;
  logic             mem_re;
  logic [AddrW:0]   rd_sum;
  logic [AddrW-1:0] mem_raddr;
  lap_entry_t       mem_wdata;
  lap_entry_t       mem_rdata;

  // Handshake: a new event enters whenever the result register is free or being taken.
  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_acc     = in_valid_i & ~in_stall_o;

  // Debounce check against the last accepted edge.
  assign edge_ok = ~edge_seen_q ||
                   ((free_q - last_edge_q) >= {{(TickW-DebounceW){1'b0}}, debounce_q});

  // Read address: newest entry sits just below the write pointer.
  assign rd_sum = {1'b0, wptr_q} + (AddrW+1)'(LAP_DEPTH - 1)
                  - {1'b0, lap_index_i[AddrW-1:0]};
  assign mem_raddr = (rd_sum >= (AddrW+1)'(LAP_DEPTH)) ?
                     AddrW'(rd_sum - (AddrW+1)'(LAP_DEPTH)) : rd_sum[AddrW-1:0];

  // Next-state logic for one event.
  always_comb begin
    run_d       = run_q;
    elapsed_d   = elapsed_q;
    free_d      = free_q;
    mark_d      = mark_q;
    count_d     = count_q;
    seq_d       = seq_q;
    wptr_d      = wptr_q;
    last_edge_d = last_edge_q;
    edge_seen_d = edge_seen_q;
    presses_d   = presses_q;
    bounces_d   = bounces_q;
    toggles_d   = toggles_q;
    taken_d     = 1'b0;
    accepted_d  = 1'b0;
    hit_d       = 1'b0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_wdata.seq      = seq_q + SeqW'(1);
    mem_wdata.interval = elapsed_q - mark_q;
    mem_wdata.mark     = elapsed_q;
    if (in_acc) begin
      unique case (func_e'(func_i))
        FUNC_TICK: begin
          free_d = free_q + TickW'(1);
          if (run_q) begin
            elapsed_d = elapsed_q + TickW'(1);
          end
        end
        FUNC_EDGE: begin
          if (edge_ok) begin
            edge_seen_d = 1'b1;
            last_edge_d = free_q;
            presses_d   = presses_q + TickW'(1);
            run_d       = ~run_q;
            toggles_d   = toggles_q + TickW'(1);
            accepted_d  = 1'b1;
          end else begin
            bounces_d = bounces_q + TickW'(1);
          end
        end
        FUNC_TOGGLE: begin
          run_d     = ~run_q;
          toggles_d = toggles_q + TickW'(1);
        end
        FUNC_RESET: begin
          run_d     = 1'b0;
          elapsed_d = '0;
          mark_d    = '0;
          count_d   = '0;
          seq_d     = '0;
        end
        FUNC_LAP: begin
          if (run_q) begin
            mem_we  = 1'b1;
            seq_d   = seq_q + SeqW'(1);
            mark_d  = elapsed_q;
            wptr_d  = (wptr_q == AddrW'(LAP_DEPTH - 1)) ? '0 : wptr_q + AddrW'(1);
            taken_d = 1'b1;
            if (count_q != CountW'(LAP_DEPTH)) begin
              count_d = count_q + CountW'(1);
            end
          end
        end
        FUNC_READ: begin
          // A stored count never exceeds the depth, so this also bounds the index.
          if (lap_index_i < IdxW'(count_q)) begin
            hit_d  = 1'b1;
            mem_re = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Result register valid.
  always_comb begin
    if (in_acc) begin
      out_valid_d = 1'b1;
    end else if (out_stall_i) begin
      out_valid_d = out_valid_q;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= DebounceRst;
    end else if (cfg_we_i) begin
      debounce_q <= cfg_wdata_i;
    end
  end

  // State and result flag registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q       <= 1'b0;
      elapsed_q   <= '0;
      free_q      <= '0;
      mark_q      <= '0;
      count_q     <= '0;
      seq_q       <= '0;
      wptr_q      <= '0;
      last_edge_q <= '0;
      edge_seen_q <= 1'b0;
      presses_q   <= '0;
      bounces_q   <= '0;
      toggles_q   <= '0;
      out_valid_q <= 1'b0;
      taken_q     <= 1'b0;
      accepted_q  <= 1'b0;
      hit_q       <= 1'b0;
    end else begin
      run_q       <= run_d;
      elapsed_q   <= elapsed_d;
      free_q      <= free_d;
      mark_q      <= mark_d;
      count_q     <= count_d;
      seq_q       <= seq_d;
      wptr_q      <= wptr_d;
      last_edge_q <= last_edge_d;
      edge_seen_q <= edge_seen_d;
      presses_q   <= presses_d;
      bounces_q   <= bounces_d;
      toggles_q   <= toggles_d;
      out_valid_q <= out_valid_d;
      if (in_acc) begin
        taken_q    <= taken_d;
        accepted_q <= accepted_d;
        hit_q      <= hit_d;
      end
    end
  end

  // Lap history memory.
  swlr_lap_mem #(
    .Depth (LAP_DEPTH),
    .AddrW (AddrW)
  ) u_lap_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (wptr_q),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // The state registers only move when a new result loads, so they are the result.
  assign out_valid_o     = out_valid_q;
  assign running_o       = run_q;
  assign elapsed_ticks_o = elapsed_q;
  assign laps_stored_o   = LapsW'(count_q);
  assign lap_taken_o     = taken_q;
  assign edge_accepted_o = accepted_q;
  assign lap_number_o    = hit_q ? mem_rdata.seq : '0;
  assign lap_interval_o  = hit_q ? mem_rdata.interval : '0;
  assign lap_elapsed_o   = hit_q ? mem_rdata.mark : '0;
  assign free_ticks_o    = free_q;
  assign press_count_o   = presses_q;
  assign bounce_count_o  = bounces_q;
  assign toggle_count_o  = toggles_q;

  // The fill count never runs past the depth.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(LAP_DEPTH))
    else $error("lap count exceeds history depth");

  // A reported lap always leaves at least one entry stored.
  a_lap_stored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && taken_q) |-> (count_q != '0))
    else $error("lap taken with empty history");

  // An accepted button edge advances the toggle counter by one.
  a_edge_toggle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (func_i == FUNC_EDGE) && edge_ok) |=>
      (toggles_q == $past(toggles_q) + TickW'(1)))
    else $error("accepted edge did not count a toggle");

  // A history hit only comes from an index below the history depth.
  a_read_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && hit_d) |-> (lap_index_i < IdxW'(LAP_DEPTH)))
    else $error("history read beyond depth");

endmodule
